### hdl/bmwle_pkg.sv
package bmwle_pkg;

   localparam int ROW_COUNT_DEFAULT = 128;
   localparam int WORDS_PER_ROW = 16;
   localparam int WORD_W = 32;
   localparam int ROW_FIELD_W = 7;
   localparam int WORD_IDX_W = 4;
   localparam int MODE_W = 2;
   localparam int OP_W = 4;
   localparam int BANK_W = 4;

   // command word layout
   localparam int CMD_A_LSB = 0;
   localparam int CMD_B_LSB = 8;
   localparam int CMD_C_LSB = 16;
   localparam int CMD_OP_LSB = 24;
   localparam int CMD_BANK_LSB = 28;

   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CMD = 2'd2;

   localparam logic [OP_W-1:0] OP_AND = 4'd1;
   localparam logic [OP_W-1:0] OP_OR = 4'd2;
   localparam logic [OP_W-1:0] OP_XOR = 4'd3;
   localparam logic [OP_W-1:0] OP_COPY = 4'd4;
   localparam logic [OP_W-1:0] OP_NOT = 4'd5;
   localparam logic [OP_W-1:0] OP_SHL1 = 4'd6;
   localparam logic [OP_W-1:0] OP_SHL4 = 4'd7;

   localparam int BANK_FIRST [BANK_W] = '{0, 8, 10, 14};

   typedef logic [2:0] step_type;

   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_WRITE = 3'd1;
   localparam step_type STEP_READ = 3'd2;
   localparam step_type STEP_READ_DONE = 3'd3;
   localparam step_type STEP_CMD = 3'd4;
   localparam step_type STEP_CLOSE = 3'd5;
   localparam step_type STEP_DELIVER = 3'd6;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_JUMP,
      COND_DISPATCH,
      COND_WORD,
      COND_OUT
   } cond_type;

   typedef struct packed {
      logic     accept;
      logic     bus_write;
      logic     bus_read;
      logic     read_done;
      logic     cmd_issue;
      logic     count_inc;
      logic     deliver;
      cond_type cond;
      step_type target;
   } ctl_type;

   typedef struct packed {
      logic              req_valid;
      logic [MODE_W-1:0] mode;
      logic              last_word;
      logic              out_free;
   } seq_status_type;

   // microprogram ROM: one control word per step
   function automatic ctl_type microcode(step_type s);
      ctl_type c;
      c = '0;
      case (s)
         STEP_IDLE: begin
            c.accept = 1'b1;
            c.cond = COND_DISPATCH;
            c.target = STEP_IDLE;
         end
         STEP_WRITE: begin
            c.bus_write = 1'b1;
            c.cond = COND_JUMP;
            c.target = STEP_DELIVER;
         end
         STEP_READ: begin
            c.bus_read = 1'b1;
            c.cond = COND_NEXT;
         end
         STEP_READ_DONE: begin
            c.read_done = 1'b1;
            c.cond = COND_JUMP;
            c.target = STEP_DELIVER;
         end
         STEP_CMD: begin
            c.cmd_issue = 1'b1;
            c.cond = COND_WORD;
            c.target = STEP_CMD;
         end
         STEP_CLOSE: begin
            c.count_inc = 1'b1;
            c.cond = COND_NEXT;
         end
         STEP_DELIVER: begin
            c.deliver = 1'b1;
            c.cond = COND_OUT;
            c.target = STEP_IDLE;
         end
         default: begin
            c.cond = COND_JUMP;
            c.target = STEP_IDLE;
         end
      endcase
      return c;
   endfunction

   function automatic step_type dispatch(logic [MODE_W-1:0] mode);
      step_type s;
      case (mode)
         MODE_WRITE: s = STEP_WRITE;
         MODE_READ: s = STEP_READ;
         MODE_CMD: s = STEP_CMD;
         default: s = STEP_DELIVER;
      endcase
      return s;
   endfunction

   function automatic logic [1:0] bank_of(logic [WORD_IDX_W-1:0] w);
      logic [1:0] b;
      if (w < WORD_IDX_W'(BANK_FIRST[1])) begin
         b = 2'd0;
      end else if (w < WORD_IDX_W'(BANK_FIRST[2])) begin
         b = 2'd1;
      end else if (w < WORD_IDX_W'(BANK_FIRST[3])) begin
         b = 2'd2;
      end else begin
         b = 2'd3;
      end
      return b;
   endfunction

endpackage

### hdl/bmwle_sequencer.sv
module bmwle_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  bmwle_pkg::seq_status_type status,
   output bmwle_pkg::ctl_type        ctl,
   output bmwle_pkg::step_type       step
);
   import bmwle_pkg::*;

   step_type step_ff;
   step_type step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctl = microcode(step_ff);
      step_in = step_ff;
      case (ctl.cond)
         COND_NEXT: step_in = step_ff + 3'd1;
         COND_JUMP: step_in = ctl.target;
         COND_DISPATCH: begin
            if (status.req_valid) begin
               step_in = dispatch(status.mode);
            end
         end
         COND_WORD: begin
            // loop on the word step until the last word is issued
            if (status.last_word) begin
               step_in = step_ff + 3'd1;
            end else begin
               step_in = ctl.target;
            end
         end
         COND_OUT: begin
            if (status.out_free) begin
               step_in = ctl.target;
            end
         end
         default: step_in = STEP_IDLE;
      endcase
   end

   assign step = step_ff;

endmodule

### hdl/bank_masked_word_logic_engine_unit.sv
// A request is taken only in the idle step, so the engine holds one request at a time.
// A command walks all 16 word slots, one per cycle, through the store's two read ports
// and its write port.
// Reset: synchronous, active high; clears the sequencer, the carries, the command
// count and the result valid. The word store is not cleared: contents are undefined
// until written.
module bank_masked_word_logic_engine_unit #(
   parameter int ROW_COUNT = bmwle_pkg::ROW_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bmwle_pkg::MODE_W-1:0]      req_mode,
   input  logic [bmwle_pkg::ROW_FIELD_W-1:0] req_row,
   input  logic [bmwle_pkg::WORD_IDX_W-1:0]  req_word_index,
   input  logic [bmwle_pkg::WORD_W-1:0]      req_data_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bmwle_pkg::WORD_W-1:0]      rsp_read_data,
   output logic [bmwle_pkg::WORD_W-1:0]      rsp_command_count
);
   import bmwle_pkg::*;

   localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int ADDR_W = ROW_W + WORD_IDX_W;
   localparam int MEM_DEPTH = ROW_COUNT * WORDS_PER_ROW;

   // row modulo ROW_COUNT by restoring subtraction, one step per bit
   function automatic logic [ROW_W-1:0] wrap_row(logic [ROW_FIELD_W-1:0] row);
      logic [14:0] r;
      logic [14:0] m;
      r = 15'(row);
      for (int s = ROW_FIELD_W - 1; s >= 0; s--) begin
         m = 15'(ROW_COUNT) << s;
         if (r >= m) begin
            r = r - m;
         end
      end
      return r[ROW_W-1:0];
   endfunction

   ctl_type        ctl;
   step_type       step;
   seq_status_type status;

   logic [WORD_W-1:0] store_ff [MEM_DEPTH];
   logic [WORD_W-1:0] mem_a_ff;
   logic [WORD_W-1:0] mem_b_ff;

   logic [ROW_FIELD_W-1:0] row_ff;
   logic [WORD_IDX_W-1:0]  widx_ff;
   logic [WORD_W-1:0]      data_ff;
   logic [WORD_IDX_W-1:0]  word_cnt_ff;
   logic                   wb_valid_ff;
   logic [WORD_IDX_W-1:0]  wb_word_ff;
   logic                   carry1_ff;
   logic [3:0]             carry4_ff;
   logic [WORD_W-1:0]      rd_ff;
   logic [WORD_W-1:0]      count_ff;
   logic                   rsp_valid_ff;
   logic [WORD_W-1:0]      rsp_read_data_ff;
   logic [WORD_W-1:0]      rsp_count_ff;

   logic                   accept;
   logic                   out_free;
   logic                   issue_sel;
   logic [ROW_W-1:0]       row_a;
   logic [ROW_W-1:0]       row_b;
   logic [ROW_W-1:0]       row_c;
   logic [ROW_W-1:0]       row_bus;
   logic [OP_W-1:0]        op;
   logic [BANK_W-1:0]      banks;
   logic [ADDR_W-1:0]      rd_addr_a;
   logic [ADDR_W-1:0]      rd_addr_b;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_wa;
   logic [WORD_W-1:0]      mem_wd;
   logic [WORD_W-1:0]      result;

   bmwle_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl),
      .step   (step)
   );

   assign req_stall = !ctl.accept;
   assign accept = req_valid && ctl.accept;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status.req_valid = req_valid;
      status.mode = req_mode;
      status.last_word = (word_cnt_ff == {WORD_IDX_W{1'b1}});
      status.out_free = out_free;
   end

   assign row_a = wrap_row(data_ff[CMD_A_LSB +: ROW_FIELD_W]);
   assign row_b = wrap_row(data_ff[CMD_B_LSB +: ROW_FIELD_W]);
   assign row_c = wrap_row(data_ff[CMD_C_LSB +: ROW_FIELD_W]);
   assign row_bus = wrap_row(row_ff);
   assign op = data_ff[CMD_OP_LSB +: OP_W];
   assign banks = data_ff[CMD_BANK_LSB +: BANK_W];
   assign issue_sel = ctl.cmd_issue && banks[bank_of(word_cnt_ff)];

   assign rd_addr_a = ctl.bus_read ? {row_bus, widx_ff} : {row_a, word_cnt_ff};
   assign rd_addr_b = {row_b, word_cnt_ff};

   always_comb begin
      case (op)
         OP_AND: result = mem_a_ff & mem_b_ff;
         OP_OR: result = mem_a_ff | mem_b_ff;
         OP_XOR: result = mem_a_ff ^ mem_b_ff;
         OP_COPY: result = mem_a_ff;
         OP_NOT: result = ~mem_a_ff;
         OP_SHL1: result = {mem_a_ff[WORD_W-2:0], carry1_ff};
         OP_SHL4: result = {mem_a_ff[WORD_W-5:0], carry4_ff};
         default: result = mem_a_ff;
      endcase
   end

   // bus writes never overlap a command's write-back
   always_comb begin
      mem_we = ctl.bus_write || wb_valid_ff;
      if (ctl.bus_write) begin
         mem_wa = {row_bus, widx_ff};
         mem_wd = data_ff;
      end else begin
         mem_wa = {row_c, wb_word_ff};
         mem_wd = result;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      mem_a_ff <= store_ff[rd_addr_a];
      mem_b_ff <= store_ff[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
         word_cnt_ff <= '0;
         carry1_ff <= 1'b0;
         carry4_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= issue_sel;
         if (accept) begin
            word_cnt_ff <= '0;
            carry1_ff <= 1'b0;
            carry4_ff <= '0;
         end else begin
            if (ctl.cmd_issue) begin
               word_cnt_ff <= word_cnt_ff + 1'b1;
            end
            // carry passes to the next processed word
            if (wb_valid_ff) begin
               carry1_ff <= mem_a_ff[WORD_W-1];
               carry4_ff <= mem_a_ff[WORD_W-1 -: 4];
            end
         end
         if (ctl.count_inc) begin
            count_ff <= count_ff + 1'b1;
         end
         if (ctl.deliver && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff <= req_row;
         widx_ff <= req_word_index;
         data_ff <= req_data_word;
         rd_ff <= '0;
      end else if (ctl.read_done) begin
         rd_ff <= mem_a_ff;
      end
      if (issue_sel) begin
         wb_word_ff <= word_cnt_ff;
      end
      if (ctl.deliver && out_free) begin
         rsp_read_data_ff <= rd_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_command_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_wb_in_command: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (step == STEP_CMD || step == STEP_CLOSE))
      else $error("write-back outside a command");

   a_one_write_port: assert property (@(posedge clock) disable iff (reset)
      !(ctl.bus_write && wb_valid_ff))
      else $error("bus write collides with write-back");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> step != STEP_IDLE)
      else $error("sequencer stayed idle after accepting a request");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> count_ff == $past(count_ff) + 1'b1)
      else $error("command count moved by other than one");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import bmwle_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic [WORD_W-1:0] command_count;
   } engine_response_type;

   class word_engine_scoreboard;
      bit [WORD_W-1:0]     word_image [2048];
      bit [WORD_W-1:0]     commands_done;
      engine_response_type awaited_responses [$];
      int                  mismatches;

      function bit selected(logic [BANK_W-1:0] mask, int w);
         int bank;
         if (w < BANK_FIRST[1]) begin
            bank = 0;
         end else if (w < BANK_FIRST[2]) begin
            bank = 1;
         end else if (w < BANK_FIRST[3]) begin
            bank = 2;
         end else begin
            bank = 3;
         end
         return mask[bank];
      endfunction

      function void apply_command(logic [WORD_W-1:0] cmd);
         logic [ROW_FIELD_W-1:0] row_a, row_b, row_c;
         logic [OP_W-1:0]        op;
         logic [BANK_W-1:0]      mask;
         logic [WORD_W-1:0]      a, b, c;
         logic                   carry1;
         logic [3:0]             carry4;
         row_a = cmd[CMD_A_LSB +: ROW_FIELD_W];
         row_b = cmd[CMD_B_LSB +: ROW_FIELD_W];
         row_c = cmd[CMD_C_LSB +: ROW_FIELD_W];
         op = cmd[CMD_OP_LSB +: OP_W];
         mask = cmd[CMD_BANK_LSB +: BANK_W];
         carry1 = 1'b0;
         carry4 = '0;
         // ascending word order, so aliased rows see earlier results
         for (int w = 0; w < WORDS_PER_ROW; w++) begin
            if (selected(mask, w)) begin
               a = word_image[{row_a, WORD_IDX_W'(w)}];
               b = word_image[{row_b, WORD_IDX_W'(w)}];
               case (op)
                  OP_AND: c = a & b;
                  OP_OR: c = a | b;
                  OP_XOR: c = a ^ b;
                  OP_NOT: c = ~a;
                  OP_SHL1: begin
                     c = {a[WORD_W-2:0], carry1};
                     carry1 = a[WORD_W-1];
                  end
                  OP_SHL4: begin
                     c = {a[WORD_W-5:0], carry4};
                     carry4 = a[WORD_W-1 -: 4];
                  end
                  default: c = a;
               endcase
               word_image[{row_c, WORD_IDX_W'(w)}] = c;
            end
         end
         commands_done++;
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [ROW_FIELD_W-1:0] row,
                                 logic [WORD_IDX_W-1:0] widx, logic [WORD_W-1:0] data);
         engine_response_type want;
         want.read_data = '0;
         case (mode)
            MODE_WRITE: word_image[{row, widx}] = data;
            MODE_READ: want.read_data = word_image[{row, widx}];
            MODE_CMD: apply_command(data);
            default: ;
         endcase
         want.command_count = commands_done;
         awaited_responses.push_back(want);
      endfunction

      function void report(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s: expected %h, actual %h", $time, what, want, got);
         end
      endfunction

      function void check_response(logic [WORD_W-1:0] read_data, logic [WORD_W-1:0] count);
         engine_response_type want;
         if (awaited_responses.size() == 0) begin
            report("response with none outstanding, read_data", '0, read_data);
            return;
         end
         want = awaited_responses.pop_front();
         if (read_data !== want.read_data) begin
            report("read_data", want.read_data, read_data);
         end
         if (count !== want.command_count) begin
            report("command_count", want.command_count, count);
         end
      endfunction

      function int outstanding();
         return awaited_responses.size();
      endfunction
   endclass

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [OP_W-1:0] OP_SPARE_LOW = 4'd0;
   localparam logic [OP_W-1:0] OP_SPARE_HIGH = 4'd15;
   localparam int REQUEST_TOTAL = 1950;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [MODE_W-1:0]      req_mode;
   logic [ROW_FIELD_W-1:0] req_row;
   logic [WORD_IDX_W-1:0]  req_word_index;
   logic [WORD_W-1:0]      req_data_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [WORD_W-1:0]      rsp_read_data;
   logic [WORD_W-1:0]      rsp_command_count;

   word_engine_scoreboard sb = new();
   bit                    written [128][WORDS_PER_ROW];
   int                    hot_rows [8];
   int                    sent;

   bank_masked_word_logic_engine_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_row           (req_row),
      .req_word_index    (req_word_index),
      .req_data_word     (req_data_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_command_count (rsp_command_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_request(req_mode, req_row, req_word_index, req_data_word);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_read_data, rsp_command_count);
      end
   end

   function automatic int pick_row();
      if ($urandom_range(9, 0) < 7) begin
         return hot_rows[$urandom_range(7, 0)];
      end
      return $urandom_range(127, 0);
   endfunction

   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [ROW_FIELD_W-1:0] row,
                               input logic [WORD_IDX_W-1:0] widx,
                               input logic [WORD_W-1:0] data);
      int gap;
      gap = (sent >= 600 && sent < 800) ? 0 : $urandom_range(15, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_row <= row;
      req_word_index <= widx;
      req_data_word <= data;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sent++;
   endtask

   task automatic send_write(input int r, input int w, input logic [WORD_W-1:0] data);
      written[r][w] = 1'b1;
      send_request(MODE_WRITE, ROW_FIELD_W'(r), WORD_IDX_W'(w), data);
   endtask

   task automatic issue_command(input int a, input int b, input int c,
                                input logic [OP_W-1:0] op, input logic [BANK_W-1:0] mask);
      logic [WORD_W-1:0] cmd;
      // never let a command read a word that was not written
      for (int w = 0; w < WORDS_PER_ROW; w++) begin
         if (sb.selected(mask, w)) begin
            if (!written[a][w]) send_write(a, w, $urandom());
            if (!written[b][w]) send_write(b, w, $urandom());
         end
      end
      cmd = $urandom();
      cmd[CMD_A_LSB +: ROW_FIELD_W] = ROW_FIELD_W'(a);
      cmd[CMD_B_LSB +: ROW_FIELD_W] = ROW_FIELD_W'(b);
      cmd[CMD_C_LSB +: ROW_FIELD_W] = ROW_FIELD_W'(c);
      cmd[CMD_OP_LSB +: OP_W] = op;
      cmd[CMD_BANK_LSB +: BANK_W] = mask;
      send_request(MODE_CMD, ROW_FIELD_W'($urandom()), WORD_IDX_W'($urandom()), cmd);
      for (int w = 0; w < WORDS_PER_ROW; w++) begin
         if (sb.selected(mask, w)) written[c][w] = 1'b1;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() > 0) @(posedge clock);
   endtask

   // response side: random stalls, a zero-stall stretch and one long hold-off
   initial begin
      int got;
      int gap;
      got = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (got == 400) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else begin
            gap = (got >= 700 && got < 900) ? 0 : $urandom_range(15, 0);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         got++;
      end
   end

   initial begin
      int               r;
      int               w;
      int               pick;
      bit               found;
      bit               drained;
      logic [OP_W-1:0]  op;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_WRITE;
      req_row <= '0;
      req_word_index <= '0;
      req_data_word <= '0;
      sent = 0;
      drained = 1'b0;
      foreach (hot_rows[i]) hot_rows[i] = $urandom_range(127, 0);
      hot_rows[0] = 0;
      hot_rows[1] = 127;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_write(0, 0, 32'hFFFF_FFFF);
      send_write(127, 15, 32'h0000_0000);
      send_request(MODE_READ, 7'd0, 4'd0, 32'hFFFF_FFFF);
      send_request(MODE_READ, 7'd127, 4'd15, 32'h0000_0000);
      send_request(MODE_UNUSED, 7'd127, 4'd15, 32'hFFFF_FFFF);
      // carry patterns in banks 1 and 3, so the carry crosses the skipped bank
      send_write(3, 8, 32'h8000_0001);
      send_write(3, 9, 32'hF000_000F);
      send_write(3, 14, 32'h7FFF_FFFE);
      send_write(3, 15, 32'hFFFF_FFFF);
      issue_command(3, 5, 127, OP_AND, 4'b1010);
      issue_command(3, 5, 127, OP_OR, 4'b1010);
      issue_command(3, 5, 127, OP_XOR, 4'b1010);
      issue_command(3, 5, 127, OP_COPY, 4'b1010);
      issue_command(3, 5, 127, OP_NOT, 4'b1010);
      issue_command(3, 5, 127, OP_SHL1, 4'b1010);
      issue_command(3, 5, 127, OP_SHL4, 4'b1010);
      issue_command(3, 5, 127, OP_SPARE_LOW, 4'b1010);
      issue_command(3, 5, 127, OP_SPARE_HIGH, 4'b1010);
      issue_command(1, 2, 4, OP_XOR, 4'b0000);
      issue_command(3, 5, 3, OP_SHL4, 4'b1010);
      send_request(MODE_READ, 7'd3, 4'd14, 32'h0000_0000);
      send_request(MODE_READ, 7'd127, 4'd9, 32'h0000_0000);

      while (sent < REQUEST_TOTAL) begin
         // hold the sender once until every response is back
         if (!drained && sent >= 1000) begin
            wait_drained();
            drained = 1'b1;
         end
         pick = $urandom_range(99, 0);
         if (pick < 30) begin
            send_write(pick_row(), $urandom_range(15, 0), $urandom());
         end else if (pick < 55) begin
            found = 1'b0;
            for (int t = 0; t < 8 && !found; t++) begin
               r = pick_row();
               w = $urandom_range(15, 0);
               found = written[r][w];
            end
            if (found) begin
               send_request(MODE_READ, ROW_FIELD_W'(r), WORD_IDX_W'(w), $urandom());
            end else begin
               send_write(r, w, $urandom());
            end
         end else if (pick < 96) begin
            if ($urandom_range(31, 0) == 0) hot_rows[$urandom_range(7, 0)] = $urandom_range(127, 0);
            op = ($urandom_range(3, 0) != 0) ? OP_W'($urandom_range(7, 1))
                                             : OP_W'($urandom_range(15, 0));
            issue_command(hot_rows[$urandom_range(7, 0)], hot_rows[$urandom_range(7, 0)],
                          pick_row(), op, BANK_W'($urandom_range(15, 0)));
         end else begin
            send_request(MODE_UNUSED, ROW_FIELD_W'($urandom()), WORD_IDX_W'($urandom()),
                         $urandom());
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("Mismatches found");
      $finish;
   end
endmodule
